### sv/voxel_grid_trilinear_sampler_unit_macros.svh
// Assertion helpers, clocked on clk with reset rst_n.
`ifndef VOXEL_GRID_TRILINEAR_SAMPLER_UNIT_MACROS_SVH
`define VOXEL_GRID_TRILINEAR_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define VGTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vgts check failed");

// next-cycle implication
`define VGTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vgts check failed");

`endif

### sv/vgts_pkg.sv
package vgts_pkg;

    localparam int MAX_DIM     = 32;
    localparam int DIM_BITS    = 5;
    localparam int SIZE_BITS   = 6;
    localparam int VALUE_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int COORD_BITS  = 21;
    localparam int INDEX_BITS  = 15;
    localparam int MAG_BITS    = 10;
    localparam int RGB_BITS    = 3 * VALUE_BITS;

    localparam logic [FRAC_BITS:0]   FRAC_ONE  = 17'h10000;
    localparam logic [FRAC_BITS-1:0] FRAC_HALF = 16'h8000;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] CFG_SIZE_X    = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y    = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z    = 2'd2;
    localparam logic [1:0] CFG_WRAP_MODE = 2'd3;

    typedef enum logic [1:0] {
        WRAP_REPEAT = 2'd0,
        WRAP_BLACK  = 2'd1,
        WRAP_WHITE  = 2'd2,
        WRAP_CLAMP  = 2'd3
    } wrap_mode_t;

    typedef enum logic [1:0] {
        K_WRITE  = 2'd0,
        K_SAMPLE = 2'd1,
        K_FILL   = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] nx;
        logic [SIZE_BITS-1:0] ny;
        logic [SIZE_BITS-1:0] nz;
        wrap_mode_t           mode;
    } cfg_t;

    typedef struct packed {
        item_kind_t                kind;
        logic [INDEX_BITS-1:0]     index;
        logic [RGB_BITS-1:0]       rgb;
        logic [2:0][DIM_BITS-1:0]  cell_idx;
        logic [2:0][FRAC_BITS:0]   frac;
    } q_item_t;

    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] r);
        logic [SIZE_BITS-1:0] n;
        if (r == '0)
            n = SIZE_BITS'(1);
        else if (r > SIZE_BITS'(MAX_DIM))
            n = SIZE_BITS'(MAX_DIM);
        else
            n = r;
        return n;
    endfunction

    // (a*(1-f) + b*f + half) >> F, rounded half up
    function automatic logic [VALUE_BITS-1:0] blend_ch(input logic [VALUE_BITS-1:0] a,
                                                       input logic [VALUE_BITS-1:0] b,
                                                       input logic [FRAC_BITS:0]    f);
        logic [FRAC_BITS:0]                 w;
        logic [VALUE_BITS+FRAC_BITS:0]      pa;
        logic [VALUE_BITS+FRAC_BITS:0]      pb;
        logic [VALUE_BITS+FRAC_BITS+1:0]    s;
        w  = FRAC_ONE - f;
        pa = (VALUE_BITS+FRAC_BITS+1)'(a) * (VALUE_BITS+FRAC_BITS+1)'(w);
        pb = (VALUE_BITS+FRAC_BITS+1)'(b) * (VALUE_BITS+FRAC_BITS+1)'(f);
        s  = (VALUE_BITS+FRAC_BITS+2)'(pa) + (VALUE_BITS+FRAC_BITS+2)'(pb)
           + (VALUE_BITS+FRAC_BITS+2)'(FRAC_HALF);
        return s[FRAC_BITS +: VALUE_BITS];
    endfunction

    function automatic logic [RGB_BITS-1:0] blend_rgb(input logic [RGB_BITS-1:0] a,
                                                      input logic [RGB_BITS-1:0] b,
                                                      input logic [FRAC_BITS:0]  f);
        logic [RGB_BITS-1:0] r;
        for (int c = 0; c < 3; c++)
            r[c*VALUE_BITS +: VALUE_BITS] = blend_ch(a[c*VALUE_BITS +: VALUE_BITS],
                                                     b[c*VALUE_BITS +: VALUE_BITS], f);
        return r;
    endfunction

endpackage

### sv/vgts_in_if.sv
interface vgts_in_if import vgts_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [INDEX_BITS-1:0]         voxel_index;
    logic [VALUE_BITS-1:0]         write_red;
    logic [VALUE_BITS-1:0]         write_green;
    logic [VALUE_BITS-1:0]         write_blue;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic signed [COORD_BITS-1:0]  point_z;

    modport source (output valid, command, voxel_index, write_red, write_green, write_blue,
                    point_x, point_y, point_z, input ready);
    modport sink   (input valid, command, voxel_index, write_red, write_green, write_blue,
                    point_x, point_y, point_z, output ready);
endinterface

### sv/vgts_out_if.sv
interface vgts_out_if import vgts_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] sample_red;
    logic [VALUE_BITS-1:0] sample_green;
    logic [VALUE_BITS-1:0] sample_blue;

    modport source (output valid, sample_red, sample_green, sample_blue, input ready);
    modport sink   (input valid, sample_red, sample_green, sample_blue, output ready);
endinterface

### sv/vgts_fifo.sv
module vgts_fifo import vgts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output q_item_t pop_item,
    output logic    empty
);
    q_item_t    mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_item = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end
endmodule

### sv/vgts_front.sv
module vgts_front import vgts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vgts_in_if.sink    in_ch,
    input  cfg_t       cfg,
    output logic       push,
    output q_item_t    push_item,
    input  logic       full
);
    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_SPLIT = 4'b0010,
        F_MOD   = 4'b0100,
        F_PUSH  = 4'b1000
    } f_state_t;

    f_state_t                      state_reg, state_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic                          cmd_reg;
    logic                          fill_reg;
    logic [INDEX_BITS-1:0]         idx_reg;
    logic [RGB_BITS-1:0]           rgb_reg;
    logic signed [COORD_BITS-1:0]  p_reg    [3];
    logic [DIM_BITS-1:0]           cell_reg [3];
    logic [FRAC_BITS:0]            frac_reg [3];
    logic [MAG_BITS-1:0]           mag_reg  [3];
    logic                          neg_reg  [3];
    logic [SIZE_BITS-1:0]          rem_reg  [3];

    logic [SIZE_BITS-1:0]          n        [3];
    logic [DIM_BITS-1:0]           s_cell   [3];
    logic [FRAC_BITS:0]            s_frac   [3];
    logic [MAG_BITS-1:0]           s_mag    [3];
    logic                          s_neg    [3];
    logic [SIZE_BITS-1:0]          m_rem    [3];
    logic [DIM_BITS-1:0]           q_cell   [3];
    logic                          outside;
    logic                          accept;

    assign n[0] = cfg.nx;
    assign n[1] = cfg.ny;
    assign n[2] = cfg.nz;

    assign in_ch.ready = (state_reg == F_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // scale by grid size, split into cell and fraction
    always_comb
    begin
        logic signed [COORD_BITS-1:0] pc;
        logic signed [COORD_BITS+SIZE_BITS-1:0] t;
        logic signed [MAG_BITS:0] c;
        logic [DIM_BITS-1:0] nm1;
        outside = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            pc = p_reg[a];
            if (cfg.mode == WRAP_CLAMP)
            begin
                if (pc < 0)
                    pc = '0;
                else if (pc > $signed(COORD_BITS'(FRAC_ONE)))
                    pc = $signed(COORD_BITS'(FRAC_ONE));
            end
            t   = (COORD_BITS+SIZE_BITS)'(pc)
                * (COORD_BITS+SIZE_BITS)'(signed'({1'b0, n[a]}));
            c   = t[COORD_BITS+SIZE_BITS-1 -: MAG_BITS+1];
            nm1 = DIM_BITS'(n[a] - SIZE_BITS'(1));
            if (cfg.mode == WRAP_CLAMP && c > signed'({6'b0, nm1}))
                s_frac[a] = FRAC_ONE;
            else
                s_frac[a] = {1'b0, t[FRAC_BITS-1:0]};
            if (c < 0)
                s_cell[a] = '0;
            else if (c > signed'({6'b0, nm1}))
                s_cell[a] = nm1;
            else
                s_cell[a] = c[DIM_BITS-1:0];
            s_neg[a] = c[MAG_BITS];
            s_mag[a] = MAG_BITS'(c[MAG_BITS] ? -c : c);
            if (p_reg[a][COORD_BITS-1] || p_reg[a][COORD_BITS-2:FRAC_BITS] != '0)
                outside = 1'b1;
        end
    end

    // one remainder bit per cycle, and the sign fix for negative cells
    always_comb
    begin
        logic [SIZE_BITS:0] rem2;
        for (int a = 0; a < 3; a++)
        begin
            rem2 = {rem_reg[a], mag_reg[a][MAG_BITS-1]};
            if (rem2 >= {1'b0, n[a]})
                m_rem[a] = SIZE_BITS'(rem2 - {1'b0, n[a]});
            else
                m_rem[a] = SIZE_BITS'(rem2);
            if (cfg.mode != WRAP_REPEAT)
                q_cell[a] = cell_reg[a];
            else if (neg_reg[a] && rem_reg[a] != '0)
                q_cell[a] = DIM_BITS'(n[a] - rem_reg[a]);
            else
                q_cell[a] = rem_reg[a][DIM_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = (in_ch.command == CMD_WRITE) ? F_PUSH : F_SPLIT;
            end
            F_SPLIT:
            begin
                cnt_next = '0;
                if ((cfg.mode == WRAP_BLACK || cfg.mode == WRAP_WHITE) && outside)
                    state_next = F_PUSH;
                else if (cfg.mode == WRAP_REPEAT)
                    state_next = F_MOD;
                else
                    state_next = F_PUSH;
            end
            F_MOD:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(MAG_BITS - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= in_ch.command;
            idx_reg  <= in_ch.voxel_index;
            rgb_reg  <= {in_ch.write_blue, in_ch.write_green, in_ch.write_red};
            p_reg[0] <= in_ch.point_x;
            p_reg[1] <= in_ch.point_y;
            p_reg[2] <= in_ch.point_z;
        end
        if (state_reg == F_SPLIT)
        begin
            fill_reg <= (cfg.mode == WRAP_BLACK || cfg.mode == WRAP_WHITE) && outside;
            for (int a = 0; a < 3; a++)
            begin
                cell_reg[a] <= s_cell[a];
                frac_reg[a] <= s_frac[a];
                mag_reg[a]  <= s_mag[a];
                neg_reg[a]  <= s_neg[a];
                rem_reg[a]  <= '0;
            end
        end
        if (state_reg == F_MOD)
        begin
            for (int a = 0; a < 3; a++)
            begin
                rem_reg[a] <= m_rem[a];
                mag_reg[a] <= {mag_reg[a][MAG_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        push            = (state_reg == F_PUSH) && !full;
        push_item.index = idx_reg;
        if (cmd_reg == CMD_WRITE)
        begin
            push_item.kind = K_WRITE;
            push_item.rgb  = rgb_reg;
        end
        else if (fill_reg)
        begin
            push_item.kind = K_FILL;
            push_item.rgb  = (cfg.mode == WRAP_WHITE) ? '1 : '0;
        end
        else
        begin
            push_item.kind = K_SAMPLE;
            push_item.rgb  = rgb_reg;
        end
        for (int a = 0; a < 3; a++)
        begin
            push_item.cell_idx[a] = q_cell[a];
            push_item.frac[a]     = frac_reg[a];
        end
    end
endmodule

### sv/vgts_back.sv
`include "voxel_grid_trilinear_sampler_unit_macros.svh"

module vgts_back import vgts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    output logic        pop,
    input  q_item_t     pop_item,
    input  logic        empty,
    vgts_out_if.source  out_ch
);
    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_ROW   = 6'b000010,
        B_BASE  = 6'b000100,
        B_READ  = 6'b001000,
        B_BLEND = 6'b010000,
        B_OUT   = 6'b100000
    } b_state_t;

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;

    b_state_t               state_reg, state_next;
    logic [3:0]             cnt_reg, cnt_next;
    q_item_t                item_reg;
    logic [9:0]             row_reg  [4];
    logic [INDEX_BITS-1:0]  base_reg [4];
    logic [RGB_BITS-1:0]    v_reg    [8];
    logic [RGB_BITS-1:0]    out_rgb_reg;
    logic                   out_valid_reg, out_valid_next;

    logic [RGB_BITS-1:0]    mem [STORE_DEPTH];
    logic [RGB_BITS-1:0]    mem_q;
    logic [INDEX_BITS-1:0]  mem_addr;
    logic                   mem_we;

    logic [DIM_BITS-1:0]    c0 [3];
    logic [DIM_BITS-1:0]    c1 [3];
    logic [SIZE_BITS-1:0]   n  [3];
    logic [RGB_BITS-1:0]    bl_a, bl_b, bl_res;
    logic [FRAC_BITS:0]     bl_f;
    logic [2:0]             bl_dst;
    logic                   out_free;

    assign n[0] = cfg.nx;
    assign n[1] = cfg.ny;
    assign n[2] = cfg.nz;

    // neighbor cell, held at the last voxel of the axis
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            c0[a] = item_reg.cell_idx[a];
            if ({1'b0, c0[a]} + SIZE_BITS'(1) < n[a])
                c1[a] = c0[a] + DIM_BITS'(1);
            else
                c1[a] = DIM_BITS'(n[a] - SIZE_BITS'(1));
        end
    end

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign mem_we   = pop && (pop_item.kind == K_WRITE);
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        if (mem_we)
            mem_addr = pop_item.index;
        else
            mem_addr = base_reg[cnt_reg[2:1]]
                     + INDEX_BITS'(cnt_reg[0] ? c1[0] : c0[0]);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= pop_item.rgb;
        mem_q <= mem[mem_addr];
    end

    // reduction order: four x blends, two y blends, one z blend
    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    begin bl_a = v_reg[0]; bl_b = v_reg[1]; bl_dst = 3'd0; end
            3'd1:    begin bl_a = v_reg[2]; bl_b = v_reg[3]; bl_dst = 3'd1; end
            3'd2:    begin bl_a = v_reg[4]; bl_b = v_reg[5]; bl_dst = 3'd2; end
            3'd3:    begin bl_a = v_reg[6]; bl_b = v_reg[7]; bl_dst = 3'd3; end
            3'd4:    begin bl_a = v_reg[0]; bl_b = v_reg[1]; bl_dst = 3'd0; end
            3'd5:    begin bl_a = v_reg[2]; bl_b = v_reg[3]; bl_dst = 3'd1; end
            default: begin bl_a = v_reg[0]; bl_b = v_reg[1]; bl_dst = 3'd0; end
        endcase
        if (cnt_reg < 4'd4)
            bl_f = item_reg.frac[0];
        else if (cnt_reg < 4'd6)
            bl_f = item_reg.frac[1];
        else
            bl_f = item_reg.frac[2];
        bl_res = blend_rgb(bl_a, bl_b, bl_f);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        case (state_reg)
            B_IDLE:
            begin
                cnt_next = '0;
                if (pop)
                begin
                    if (pop_item.kind == K_SAMPLE)
                        state_next = B_ROW;
                    else if (pop_item.kind == K_FILL)
                        state_next = B_OUT;
                end
            end
            B_ROW:
                state_next = B_BASE;
            B_BASE:
                state_next = B_READ;
            B_READ:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    cnt_next   = '0;
                    state_next = B_BLEND;
                end
            end
            B_BLEND:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd6)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= pop_item;
            v_reg[0] <= pop_item.rgb;
        end
        if (state_reg == B_ROW)
        begin
            for (int j = 0; j < 4; j++)
                row_reg[j] <= 10'(11'(j[1] ? c1[2] : c0[2]) * 11'(n[1])
                                 + 11'(j[0] ? c1[1] : c0[1]));
        end
        if (state_reg == B_BASE)
        begin
            for (int j = 0; j < 4; j++)
                base_reg[j] <= INDEX_BITS'(16'(row_reg[j]) * 16'(n[0]));
        end
        if (state_reg == B_READ && cnt_reg != 4'd0)
            v_reg[3'(cnt_reg - 4'd1)] <= mem_q;
        if (state_reg == B_BLEND)
            v_reg[bl_dst] <= bl_res;
        if (state_reg == B_OUT && out_free)
            out_rgb_reg <= v_reg[0];
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sample_red   = out_rgb_reg[0 +: VALUE_BITS];
    assign out_ch.sample_green = out_rgb_reg[VALUE_BITS +: VALUE_BITS];
    assign out_ch.sample_blue  = out_rgb_reg[2*VALUE_BITS +: VALUE_BITS];

    `VGTS_ASSERT_NOW(a_pop_idle, pop, state_reg == B_IDLE)
    `VGTS_ASSERT_NXT(a_read_done, (state_reg == B_READ) && (cnt_reg == 4'd8),
                     state_reg == B_BLEND)
    `VGTS_ASSERT_NXT(a_out_wait, (state_reg == B_OUT) && out_valid_reg && !out_ch.ready,
                     (state_reg == B_OUT) && out_valid_reg)
endmodule

### sv/voxel_grid_trilinear_sampler_unit.sv
// Trilinear sampler over a 32x32x32 grid of red/green/blue voxels.
// in_ch (valid/ready): a request is either a voxel write (command 0, voxel_index
//   plus three channels) or a sample (command 1, signed Q4.16 point).
// out_ch (valid/ready): one result per sample request, none per write.
// cfg_we/cfg_index/cfg_wdata: size_x, size_y, size_z, wrap_mode; write only
//   while no request is in flight.
// Front end registers the request, scales a sample's point and, in repeat
//   mode, runs a bit-serial remainder on each axis; then a 2-deep queue.
// Back end: address math (row, then base), eight reads through the one
//   single-port voxel memory, the blends, then it loads the output register.
// The back end takes one sample at a time, paced by its memory fetch and
//   shared blend unit; meanwhile the front end can queue further requests.
// Reset: sizes 32, repeat mode, queue and output empty; voxel memory is not
//   cleared and must be written before it is sampled.
// A stalled output holds its result; the back end waits, the queue fills, and
//   in_ch.ready then drops.
module voxel_grid_trilinear_sampler_unit import vgts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    vgts_in_if.sink          in_ch,
    vgts_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [SIZE_BITS-1:0] cfg_wdata
);
    logic [SIZE_BITS-1:0] size_x_reg, size_y_reg, size_z_reg;
    wrap_mode_t           wrap_reg;
    cfg_t                 cfg;

    logic    push, full, pop, empty;
    q_item_t push_item, pop_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_BITS'(MAX_DIM);
            size_y_reg <= SIZE_BITS'(MAX_DIM);
            size_z_reg <= SIZE_BITS'(MAX_DIM);
            wrap_reg   <= WRAP_REPEAT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIZE_X:    size_x_reg <= cfg_wdata;
                CFG_SIZE_Y:    size_y_reg <= cfg_wdata;
                CFG_SIZE_Z:    size_z_reg <= cfg_wdata;
                CFG_WRAP_MODE: wrap_reg   <= wrap_mode_t'(cfg_wdata[1:0]);
                default:       ;
            endcase
        end
    end

    // zero acts as 1, above the grid acts as the grid size
    assign cfg.nx   = eff_size(size_x_reg);
    assign cfg.ny   = eff_size(size_y_reg);
    assign cfg.nz   = eff_size(size_z_reg);
    assign cfg.mode = wrap_reg;

    vgts_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    vgts_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    vgts_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pop      (pop),
        .pop_item (pop_item),
        .empty    (empty),
        .out_ch   (out_ch)
    );
endmodule
